FILE: rtl/hda_pkg.sv
// ----------------------------------------------------------------------------
// hda_pkg
// Shared types and constants of the tag hourly distance accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package hda_pkg;

  localparam int unsigned HOUR_COUNT = 24;
  localparam int unsigned HOUR_MAX   = 23;
  localparam int unsigned TAG_IN_W   = 4;
  localparam int unsigned HOUR_W     = 5;
  localparam int unsigned DAY_W      = 5;
  localparam int unsigned STATUS_W   = 2;

  localparam logic [STATUS_W-1:0] STATUS_STEP   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REF    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MATCH,
    ST_SQX,
    ST_SQY,
    ST_ROOT,
    ST_ACCUM,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic square_x;
    logic square_y;
    logic root_step;
  } arith_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/hda_arith.sv
// ----------------------------------------------------------------------------
// hda_arith
// Shared arithmetic unit: squares two deltas with one multiplier, then takes
// the floor square root one result bit per step.
// ----------------------------------------------------------------------------
`default_nettype none

module hda_arith #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 4
) (
  input  wire logic                                 clk_i,
  input  wire hda_pkg::arith_cmd_t                  cmd_i,
  input  wire logic [COORD_BITS-1:0]                dx_i,
  input  wire logic [COORD_BITS-1:0]                dy_i,
  output logic      [COORD_BITS+FRAC_BITS:0]        root_o
);
  import hda_pkg::*;

  localparam int unsigned ROOT_W = COORD_BITS + 1 + FRAC_BITS;
  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam int unsigned PROD_W = 2 * COORD_BITS;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned REM_W  = ROOT_W + 2;

  logic [COORD_BITS-1:0] operand;
  logic [PROD_W-1:0]     prod;
  logic [SUM_W-1:0]      sum;
  logic [PROD_W-1:0]     acc_q;
  logic [RAD_W-1:0]      rad_q;
  logic [REM_W-1:0]      rem_q;
  logic [ROOT_W-1:0]     root_q;
  logic [REM_W-1:0]      rem_sh;
  logic [REM_W-1:0]      trial;
  logic                  fits;

  assign operand = cmd_i.square_y ? dy_i : dx_i;
  assign prod    = PROD_W'(operand) * PROD_W'(operand);
  assign sum     = SUM_W'(acc_q) + SUM_W'(prod);

  assign rem_sh  = {rem_q[ROOT_W-1:0], rad_q[RAD_W-1 -: 2]};
  assign trial   = {root_q, 2'b01};
  assign fits    = rem_sh >= trial;

  always_ff @(posedge clk_i) begin
    if (cmd_i.square_x) begin
      acc_q <= prod;
    end
    if (cmd_i.square_y) begin
      rad_q  <= RAD_W'(sum) << (2 * FRAC_BITS);
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      rad_q <= rad_q << 2;
      if (fits) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign root_o = root_q;

endmodule

`default_nettype wire

FILE: rtl/tag_hourly_distance_accumulator_top.sv
// ----------------------------------------------------------------------------
// tag_hourly_distance_accumulator_top
// Per-tag, per-hour accumulation of the distance between position samples.
//
//  channel  dir  tdata (low bit up)                          tuser
//  s_axis   in   tag_index, pos_x, pos_y, hour_of_day,       -
//                day_of_month
//  m_axis   out  step_distance, hour_total                   status
//
// A rejected sample goes straight to the result stage, a new reference after the
// reference read and compare, and a step after squaring and the bit-serial square
// root, which makes one result bit per cycle.
// After reset a clearing pass writes zero to all 24 * TAG_COUNT totals before
// the first item is taken.
// One item is in work at a time; a result waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tag_hourly_distance_accumulator_top #(
  parameter int unsigned TAG_COUNT  = 16,
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 4,
  parameter int unsigned TOTAL_BITS = 40
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // tag_index, pos_x, pos_y, hour_of_day, day_of_month
  input  wire logic [((2*COORD_BITS+2+hda_pkg::TAG_IN_W+hda_pkg::HOUR_W+hda_pkg::DAY_W+7)/8)*8-1:0]
                    s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // step_distance, hour_total
  output logic [((COORD_BITS+1+FRAC_BITS+TOTAL_BITS+7)/8)*8-1:0] m_axis_tdata,
  // status
  output logic [hda_pkg::STATUS_W-1:0] m_axis_tuser
);
  import hda_pkg::*;

  localparam int unsigned POS_W    = COORD_BITS + 1;
  localparam int unsigned STEP_W   = COORD_BITS + 1 + FRAC_BITS;
  localparam int unsigned OUT_RAW  = STEP_W + TOTAL_BITS;
  localparam int unsigned OUT_W    = ((OUT_RAW + 7) / 8) * 8;
  localparam int unsigned TAG_W    = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1;
  localparam int unsigned SLOT_CNT = HOUR_COUNT * TAG_COUNT;
  localparam int unsigned SLOT_W   = $clog2(SLOT_CNT);
  localparam int unsigned CNT_W    = $clog2(STEP_W);
  localparam int unsigned SUM_W    = ((TOTAL_BITS > STEP_W) ? TOTAL_BITS : STEP_W) + 1;
  localparam int unsigned X_LSB    = TAG_IN_W;
  localparam int unsigned Y_LSB    = X_LSB + POS_W;
  localparam int unsigned H_LSB    = Y_LSB + POS_W;
  localparam int unsigned D_LSB    = H_LSB + HOUR_W;

  state_e state_q, state_d;

  logic [TAG_IN_W-1:0]   in_tag;
  logic [POS_W-1:0]      in_x;
  logic [POS_W-1:0]      in_y;
  logic [HOUR_W-1:0]     in_hour;
  logic [DAY_W-1:0]      in_day;
  logic                  in_reject;
  logic                  accept;

  logic [TAG_W-1:0]      tag_lut [16];
  logic [TAG_W-1:0]      tag_q;
  logic [COORD_BITS-1:0] x_q, y_q;
  logic [HOUR_W-1:0]     hour_q;
  logic [DAY_W-1:0]      day_q;
  logic [SLOT_W-1:0]     slot;

  logic                  has_ref_q [TAG_COUNT];
  logic [COORD_BITS-1:0] last_x_q [TAG_COUNT];
  logic [COORD_BITS-1:0] last_y_q [TAG_COUNT];
  logic [HOUR_W-1:0]     last_hour_q [TAG_COUNT];
  logic [DAY_W-1:0]      last_day_q [TAG_COUNT];

  logic                  match_q;
  logic [COORD_BITS-1:0] dx_q, dy_q;

  logic [TOTAL_BITS-1:0] total_mem [SLOT_CNT];
  logic [TOTAL_BITS-1:0] rd_q;
  logic                  mem_we;
  logic [SLOT_W-1:0]     mem_addr;
  logic [TOTAL_BITS-1:0] mem_wdata;
  logic [SLOT_W-1:0]     clr_q;

  logic [CNT_W-1:0]      cnt_q;
  arith_cmd_t            cmd;
  logic [STEP_W-1:0]     root;
  logic [SUM_W-1:0]      total_sum;
  logic [TOTAL_BITS-1:0] total_sat;

  logic [STATUS_W-1:0]   res_status_q;
  logic [TOTAL_BITS-1:0] res_total_q;
  logic [STEP_W-1:0]     res_step;
  logic                  out_load;
  logic                  m_valid_q;
  logic [OUT_W-1:0]      m_data_q;
  logic [STATUS_W-1:0]   m_user_q;

  genvar g;
  for (g = 0; g < 16; g++) begin : g_tag_lut
    assign tag_lut[g] = TAG_W'(g % TAG_COUNT);
  end

  assign in_tag    = s_axis_tdata[TAG_IN_W-1:0];
  assign in_x      = s_axis_tdata[X_LSB +: POS_W];
  assign in_y      = s_axis_tdata[Y_LSB +: POS_W];
  assign in_hour   = s_axis_tdata[H_LSB +: HOUR_W];
  assign in_day    = s_axis_tdata[D_LSB +: DAY_W];
  assign in_reject = in_x[COORD_BITS] | in_y[COORD_BITS] | (in_hour > HOUR_W'(HOUR_MAX));
  assign accept    = s_axis_tvalid & s_axis_tready;

  assign slot = SLOT_W'(int'(hour_q) * TAG_COUNT + int'(tag_q));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == SLOT_W'(SLOT_CNT - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = in_reject ? ST_DONE : ST_READ;
      end
      ST_READ:  state_d = ST_MATCH;
      ST_MATCH: state_d = match_q ? ST_SQX : ST_DONE;
      ST_SQX:   state_d = ST_SQY;
      ST_SQY:   state_d = ST_ROOT;
      ST_ROOT:  if (cnt_q == CNT_W'(STEP_W - 1)) state_d = ST_ACCUM;
      ST_ACCUM: state_d = ST_DONE;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    cmd           = '0;
    mem_we        = 1'b0;
    mem_addr      = slot;
    mem_wdata     = total_sat;
    out_load      = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
      end
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_SQX:   cmd.square_x = 1'b1;
      ST_SQY:   cmd.square_y = 1'b1;
      ST_ROOT:  cmd.root_step = 1'b1;
      ST_ACCUM: mem_we = 1'b1;
      ST_DONE:  out_load = ~m_valid_q | m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == ST_SQY) begin
        cnt_q <= '0;
      end else if (state_q == ST_ROOT) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // sample capture, reference compare, result hold
  always_ff @(posedge clk_i) begin
    if (accept) begin
      tag_q        <= tag_lut[in_tag];
      x_q          <= in_x[COORD_BITS-1:0];
      y_q          <= in_y[COORD_BITS-1:0];
      hour_q       <= in_hour;
      day_q        <= in_day;
      res_status_q <= in_reject ? STATUS_REJECT : STATUS_STEP;
      res_total_q  <= '0;
    end
    if (state_q == ST_READ) begin
      match_q <= has_ref_q[tag_q] && (last_hour_q[tag_q] == hour_q) &&
                 (last_day_q[tag_q] == day_q);
      dx_q    <= (x_q >= last_x_q[tag_q]) ? x_q - last_x_q[tag_q] : last_x_q[tag_q] - x_q;
      dy_q    <= (y_q >= last_y_q[tag_q]) ? y_q - last_y_q[tag_q] : last_y_q[tag_q] - y_q;
    end
    if (state_q == ST_MATCH && !match_q) begin
      res_status_q <= STATUS_REF;
      res_total_q  <= rd_q;
    end
    if (state_q == ST_ACCUM) begin
      res_total_q <= total_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAG_COUNT; i++) has_ref_q[i] <= 1'b0;
    end else if (out_load && res_status_q == STATUS_REF) begin
      has_ref_q[tag_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && res_status_q != STATUS_REJECT) begin
      last_x_q[tag_q] <= x_q;
      last_y_q[tag_q] <= y_q;
      if (res_status_q == STATUS_REF) begin
        last_hour_q[tag_q] <= hour_q;
        last_day_q[tag_q]  <= day_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) total_mem[mem_addr] <= mem_wdata;
    rd_q <= total_mem[slot];
  end

  hda_arith #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_arith (
    .clk_i  (clk_i),
    .cmd_i  (cmd),
    .dx_i   (dx_q),
    .dy_i   (dy_q),
    .root_o (root)
  );

  assign total_sum = SUM_W'(rd_q) + SUM_W'(root);
  assign total_sat = (total_sum > SUM_W'({TOTAL_BITS{1'b1}})) ? {TOTAL_BITS{1'b1}}
                                                              : total_sum[TOTAL_BITS-1:0];
  assign res_step  = (res_status_q == STATUS_STEP) ? root : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= OUT_W'({res_total_q, res_step});
      m_user_q <= res_status_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == STATUS_STEP || m_axis_tuser == STATUS_REF ||
                       m_axis_tuser == STATUS_REJECT))
    else $error("undefined status code");

  a_step_only_on_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != STATUS_STEP) |-> (m_axis_tdata[STEP_W-1:0] == '0))
    else $error("nonzero step without an added step");

  a_reject_zero_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == STATUS_REJECT) |->
      (m_axis_tdata[STEP_W +: TOTAL_BITS] == '0))
    else $error("rejected item carries a total");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready)
    else $error("input ready during clearing pass");
`endif

endmodule

`default_nettype wire

FILE: test/tb_hda_checker.sv
// ----------------------------------------------------------------------------
// tb_hda_checker
// Watches both streams of the tag hourly distance accumulator. Every accepted
// sample runs through a local model of the per-tag reference and the per-hour
// totals. Every result that leaves the block is compared, field by field, with
// the oldest predicted result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_hda_checker #(
  parameter int unsigned TAG_COUNT  = 16,
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 4,
  parameter int unsigned TOTAL_BITS = 40,
  parameter int unsigned IN_W       = 40,
  parameter int unsigned OUT_W      = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  input  wire logic                         s_axis_tready,
  input  wire logic [IN_W-1:0]              s_axis_tdata,
  input  wire logic                         m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  input  wire logic [OUT_W-1:0]             m_axis_tdata,
  input  wire logic [hda_pkg::STATUS_W-1:0] m_axis_tuser,
  output int                                pending_o,
  output int                                failures_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POS_W    = COORD_BITS + 1;
  localparam int unsigned STEP_W   = COORD_BITS + 1 + FRAC_BITS;
  localparam int unsigned SLOT_NUM = hda_pkg::HOUR_COUNT * TAG_COUNT;

  typedef struct packed {
    logic [hda_pkg::STATUS_W-1:0] status;
    logic [STEP_W-1:0]            step;
    logic [TOTAL_BITS-1:0]        total;
  } result_t;

  result_t                     result_q[$];
  logic [COORD_BITS-1:0]       ref_x[TAG_COUNT];
  logic [COORD_BITS-1:0]       ref_y[TAG_COUNT];
  logic [hda_pkg::HOUR_W-1:0]  ref_hour[TAG_COUNT];
  logic [hda_pkg::DAY_W-1:0]   ref_day[TAG_COUNT];
  logic                        ref_valid[TAG_COUNT];
  logic [TOTAL_BITS-1:0]       hour_sum[SLOT_NUM];

  initial begin
    pending_o  = 0;
    failures_o = 0;
    for (int t = 0; t < TAG_COUNT; t++) begin
      ref_x[t]     = '0;
      ref_y[t]     = '0;
      ref_hour[t]  = '0;
      ref_day[t]   = '0;
      ref_valid[t] = 1'b0;
    end
    for (int s = 0; s < SLOT_NUM; s++) begin
      hour_sum[s] = '0;
    end
  end

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned rem;
    longint unsigned acc;
    longint unsigned one;
    rem = v;
    acc = 0;
    one = 64'd1 << 62;
    while (one > rem) one >>= 2;
    while (one != 0) begin
      if (rem >= acc + one) begin
        rem -= acc + one;
        acc = (acc >> 1) + one;
      end else begin
        acc >>= 1;
      end
      one >>= 2;
    end
    return acc;
  endfunction

  function automatic result_t distance_update(logic [IN_W-1:0] d);
    int unsigned                tag;
    logic [POS_W-1:0]           xr;
    logic [POS_W-1:0]           yr;
    logic [hda_pkg::HOUR_W-1:0] hour;
    logic [hda_pkg::DAY_W-1:0]  day;
    int unsigned                slot;
    longint unsigned            cx;
    longint unsigned            cy;
    longint unsigned            dx;
    longint unsigned            dy;
    longint unsigned            step;
    logic [TOTAL_BITS:0]        sum;
    result_t                    r;
    tag  = d[hda_pkg::TAG_IN_W-1:0] % TAG_COUNT;
    xr   = d[hda_pkg::TAG_IN_W +: POS_W];
    yr   = d[hda_pkg::TAG_IN_W + POS_W +: POS_W];
    hour = d[hda_pkg::TAG_IN_W + 2*POS_W +: hda_pkg::HOUR_W];
    day  = d[hda_pkg::TAG_IN_W + 2*POS_W + hda_pkg::HOUR_W +: hda_pkg::DAY_W];
    r    = '0;
    if (xr[COORD_BITS] || yr[COORD_BITS] || hour > hda_pkg::HOUR_MAX) begin
      r.status = hda_pkg::STATUS_REJECT;
      return r;
    end
    slot = hour * TAG_COUNT + tag;
    cx   = xr[COORD_BITS-1:0];
    cy   = yr[COORD_BITS-1:0];
    if (ref_valid[tag] && ref_hour[tag] == hour && ref_day[tag] == day) begin
      dx   = (cx >= ref_x[tag]) ? cx - ref_x[tag] : ref_x[tag] - cx;
      dy   = (cy >= ref_y[tag]) ? cy - ref_y[tag] : ref_y[tag] - cy;
      step = root_floor((dx * dx + dy * dy) << (2 * FRAC_BITS));
      step &= (64'd1 << STEP_W) - 1;
      sum  = {1'b0, hour_sum[slot]} + step[STEP_W-1:0];
      hour_sum[slot] = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
      r.status = hda_pkg::STATUS_STEP;
      r.step   = step[STEP_W-1:0];
    end else begin
      ref_hour[tag]  = hour;
      ref_day[tag]   = day;
      ref_valid[tag] = 1'b1;
      r.status       = hda_pkg::STATUS_REF;
    end
    ref_x[tag] = cx[COORD_BITS-1:0];
    ref_y[tag] = cy[COORD_BITS-1:0];
    r.total    = hour_sum[slot];
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned expected, longint unsigned actual);
    if (expected != actual) begin
      $error("%s expected %0d actual %0d", name, expected, actual);
      failures_o++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        result_q.push_back(distance_update(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          $error("result with no sample waiting: status %0d step %0d total %0d",
                 m_axis_tuser, m_axis_tdata[STEP_W-1:0], m_axis_tdata[STEP_W +: TOTAL_BITS]);
          failures_o++;
        end else begin
          want = result_q.pop_front();
          check_field("status", want.status, m_axis_tuser);
          check_field("step_distance", want.step, m_axis_tdata[STEP_W-1:0]);
          check_field("hour_total", want.total, m_axis_tdata[STEP_W +: TOTAL_BITS]);
          check_field("tdata padding", 0, m_axis_tdata >> (STEP_W + TOTAL_BITS));
        end
      end
      pending_o = result_q.size();
    end
  end

endmodule

`default_nettype wire

FILE: test/tb_tag_hourly_distance_accumulator_top.sv
// ----------------------------------------------------------------------------
// tb_tag_hourly_distance_accumulator_top
// Drives position samples into the accumulator: a directed set of
// rejections, first references, day and hour changes and extreme steps,
// then random per-tag tracks that mostly stay within one hour and day so that
// totals build up. Bursty input and patterned output back-pressure. The
// checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_tag_hourly_distance_accumulator_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TAG_COUNT  = 16;
  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned FRAC_BITS  = 4;
  localparam int unsigned TOTAL_BITS = 40;
  localparam int unsigned POS_W      = COORD_BITS + 1;
  localparam int unsigned COORD_MAX  = (1 << COORD_BITS) - 1;
  localparam int unsigned IN_W  = ((2*COORD_BITS + 2 + hda_pkg::TAG_IN_W + hda_pkg::HOUR_W
                                    + hda_pkg::DAY_W + 7) / 8) * 8;
  localparam int unsigned OUT_W = ((COORD_BITS + 1 + FRAC_BITS + TOTAL_BITS + 7) / 8) * 8;
  localparam int unsigned SAMPLE_COUNT = 1050;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic [IN_W-1:0]              s_axis_tdata  = '0;
  logic                         m_axis_tready = 1'b0;
  logic                         s_axis_tready;
  logic                         m_axis_tvalid;
  logic [OUT_W-1:0]             m_axis_tdata;
  logic [hda_pkg::STATUS_W-1:0] m_axis_tuser;
  int                           pending_count;
  int                           failure_count;

  int          burst_left = 0;
  logic [15:0] ready_pattern = '1;
  logic [3:0]  pattern_pos = '0;
  int          pattern_left = 0;
  int          trk_x[TAG_COUNT];
  int          trk_y[TAG_COUNT];
  int          trk_hour[TAG_COUNT];
  int          trk_day[TAG_COUNT];

  always #6 clk_i = ~clk_i;

  tag_hourly_distance_accumulator_top #(
    .TAG_COUNT (TAG_COUNT),
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .TOTAL_BITS(TOTAL_BITS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  tb_hda_checker #(
    .TAG_COUNT (TAG_COUNT),
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .TOTAL_BITS(TOTAL_BITS),
    .IN_W      (IN_W),
    .OUT_W     (OUT_W)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .pending_o    (pending_count),
    .failures_o   (failure_count)
  );

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (pattern_left == 0) begin
      pattern_left = $urandom_range(16, 128);
      case ($urandom_range(0, 3))
        0: ready_pattern = '1;
        1: ready_pattern = 16'($urandom);
        2: ready_pattern = 16'h0001 << $urandom_range(0, 15);
        default: ready_pattern = ~(16'h0003 << $urandom_range(0, 14));
      endcase
    end
    pattern_left--;
    pattern_pos = pattern_pos + 1'b1;
    m_axis_tready <= ready_pattern[pattern_pos];
  end

  function automatic logic [IN_W-1:0] pack_sample(int tag, int x, int y, int hour, int day);
    logic [IN_W-1:0] d;
    d = '0;
    d[hda_pkg::TAG_IN_W-1:0] = hda_pkg::TAG_IN_W'(tag);
    d[hda_pkg::TAG_IN_W +: POS_W] = POS_W'(x);
    d[hda_pkg::TAG_IN_W + POS_W +: POS_W] = POS_W'(y);
    d[hda_pkg::TAG_IN_W + 2*POS_W +: hda_pkg::HOUR_W] = hda_pkg::HOUR_W'(hour);
    d[hda_pkg::TAG_IN_W + 2*POS_W + hda_pkg::HOUR_W +: hda_pkg::DAY_W] = hda_pkg::DAY_W'(day);
    return d;
  endfunction

  task automatic send_sample(int tag, int x, int y, int hour, int day);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_sample(tag, x, y, hour, day);
    do @(posedge clk_i); while (!s_axis_tready);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 10);
    end else begin
      burst_left--;
    end
  endtask

  function automatic int wander(int pos);
    int p;
    p = pos + $urandom_range(0, 400) - 200;
    if (p < 0) p = 0;
    if (p > COORD_MAX) p = COORD_MAX;
    return p;
  endfunction

  initial begin
    int tag;
    int kind;
    int x;
    int y;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_sample(0, -1, 5, 3, 4);
    send_sample(1, 7, -4096, 3, 4);
    send_sample(2, -4096, -1, 0, 0);
    send_sample(3, 10, 10, 24, 1);
    send_sample(4, 10, 10, 31, 31);
    send_sample(0, 0, 0, 0, 1);
    send_sample(0, COORD_MAX, COORD_MAX, 0, 1);
    send_sample(0, 0, COORD_MAX, 0, 1);
    send_sample(0, 0, COORD_MAX, 0, 1);
    send_sample(0, 3, 4, 0, 2);
    send_sample(0, 0, 0, 0, 2);
    send_sample(0, -5, 0, 0, 2);
    send_sample(0, 3, 4, 0, 2);
    send_sample(0, 3, 4, 1, 2);
    send_sample(15, COORD_MAX, 0, 23, 31);
    send_sample(15, 0, 0, 23, 31);
    send_sample(15, 0, COORD_MAX, 23, 31);
    send_sample(15, 100, 200, 23, 0);
    send_sample(15, 101, 201, 23, 0);
    send_sample(7, 1234, 2345, 12, 15);
    send_sample(7, 2345, 1234, 12, 15);
    send_sample(1, 5, 5, 3, 4);

    for (int t = 0; t < TAG_COUNT; t++) begin
      trk_x[t]    = $urandom_range(0, COORD_MAX);
      trk_y[t]    = $urandom_range(0, COORD_MAX);
      trk_hour[t] = $urandom_range(0, hda_pkg::HOUR_MAX);
      trk_day[t]  = $urandom_range(0, 31);
    end

    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      tag  = $urandom_range(0, TAG_COUNT - 1);
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
        x = $urandom_range(0, 8191);
        y = $urandom_range(0, 8191);
        if ($urandom_range(0, 1)) x |= 4096;
        else y |= 4096;
        send_sample(tag, x, y, $urandom_range(0, 31), $urandom_range(0, 31));
      end else if (kind < 9) begin
        send_sample(tag, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                    $urandom_range(hda_pkg::HOUR_MAX + 1, 31), $urandom_range(0, 31));
      end else begin
        if (kind < 13) begin
          trk_hour[tag] = $urandom_range(0, hda_pkg::HOUR_MAX);
          trk_day[tag]  = $urandom_range(0, 31);
        end else if (kind < 17) begin
          if (trk_hour[tag] == hda_pkg::HOUR_MAX) begin
            trk_hour[tag] = 0;
            trk_day[tag]  = (trk_day[tag] + 1) % 32;
          end else begin
            trk_hour[tag]++;
          end
        end
        if ($urandom_range(0, 9) < 3) begin
          trk_x[tag] = $urandom_range(0, COORD_MAX);
          trk_y[tag] = $urandom_range(0, COORD_MAX);
        end else begin
          trk_x[tag] = wander(trk_x[tag]);
          trk_y[tag] = wander(trk_y[tag]);
        end
        send_sample(tag, trk_x[tag], trk_y[tag], trk_hour[tag], trk_day[tag]);
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (failure_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
